>>> rtl/twbl_pkg.sv
// ----------------------------------------------------------------------------
// twbl_pkg
// Shared types and codes of the two-wire handshake byte link.
// ----------------------------------------------------------------------------
package twbl_pkg;

  localparam int unsigned LinesW  = 2;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned WaitW   = 16;

  localparam logic [WaitW-1:0] WaitLimitReset = 16'd1000;

  // operation codes
  localparam logic [1:0] OpTick    = 2'd0;
  localparam logic [1:0] OpStartTx = 2'd1;
  localparam logic [1:0] OpStartRx = 2'd2;

  // phase codes
  localparam logic [PhaseW-1:0] PhIdle     = 3'd0;
  localparam logic [PhaseW-1:0] PhSendLow  = 3'd1;
  localparam logic [PhaseW-1:0] PhSendHigh = 3'd2;
  localparam logic [PhaseW-1:0] PhRecvPull = 3'd3;
  localparam logic [PhaseW-1:0] PhRecvRel  = 3'd4;

  // status codes
  localparam logic [StatusW-1:0] StNone    = 3'd0;
  localparam logic [StatusW-1:0] StDone    = 3'd1;
  localparam logic [StatusW-1:0] StTimeout = 3'd2;
  localparam logic [StatusW-1:0] StLinkErr = 3'd3;
  localparam logic [StatusW-1:0] StIgnored = 3'd4;

  localparam logic [LinesW-1:0]  LinesNone = 2'b00;
  localparam logic [LinesW-1:0]  LinesBoth = 2'b11;
  localparam logic [BitIdxW-1:0] LastBit   = 3'd7;

  localparam logic [WaitW-1:0] CfgAddrWaitLimit = '0;

  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic               is_receive;
    logic [ByteW-1:0]   shift_byte;
    logic [BitIdxW-1:0] bit_index;
    logic [WaitW-1:0]   wait_count;
    logic [LinesW-1:0]  drive_lines;
  } link_state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ByteW-1:0]  tx_byte;
    logic [LinesW-1:0] partner_pull;
  } link_in_t;

  typedef struct packed {
    logic              busy_res;
    logic [ByteW-1:0]  rx_byte;
    logic [StatusW-1:0] status;
    logic [LinesW-1:0] our_pull;
  } link_out_t;

endpackage

>>> rtl/twbl_step.sv
// ----------------------------------------------------------------------------
// twbl_step
// Next-state and result logic for one sampled tick of the link wires.
// ----------------------------------------------------------------------------
module twbl_step
  import twbl_pkg::*;
(
  input  link_state_t       state_i,
  input  link_in_t          item_i,
  input  logic [WaitW-1:0]  wait_limit_i,
  output link_state_t       state_o,
  output link_out_t         result_o
);

  always_comb begin
    link_state_t        nxt;
    logic               ignored;
    logic [StatusW-1:0] status;
    logic [LinesW-1:0]  high;
    logic [WaitW-1:0]   wc_inc;
    logic               timeout;
    logic               tick;

    nxt     = state_i;
    ignored = 1'b0;
    status  = StNone;
    tick    = 1'b0;

    if (nxt.phase > PhRecvRel) begin
      nxt.phase       = PhIdle;
      nxt.drive_lines = LinesNone;
      nxt.wait_count  = '0;
    end

    if (item_i.operation == OpStartTx || item_i.operation == OpStartRx) begin
      if (nxt.phase != PhIdle) begin
        ignored = 1'b1;
      end else if (item_i.operation == OpStartTx) begin
        nxt.is_receive  = 1'b0;
        nxt.shift_byte  = item_i.tx_byte;
        nxt.bit_index   = '0;
        nxt.wait_count  = '0;
        nxt.drive_lines = {item_i.tx_byte[0], ~item_i.tx_byte[0]};
        nxt.phase       = PhSendLow;
      end else begin
        nxt.is_receive  = 1'b1;
        nxt.shift_byte  = '0;
        nxt.bit_index   = '0;
        nxt.wait_count  = '0;
        nxt.drive_lines = LinesNone;
        nxt.phase       = PhRecvPull;
      end
    end

    // a line reads high only when neither side pulls it
    high    = ~(nxt.drive_lines | item_i.partner_pull);
    wc_inc  = nxt.wait_count + 16'd1;
    timeout = (wc_inc >= wait_limit_i) || (wc_inc == '0);

    unique case (nxt.phase)
      PhSendLow: begin
        if (high == LinesNone) begin
          nxt.drive_lines = LinesNone;
          nxt.wait_count  = '0;
          nxt.phase       = PhSendHigh;
        end else begin
          tick = 1'b1;
        end
      end
      PhSendHigh: begin
        if (high == LinesBoth) begin
          nxt.wait_count = '0;
          if (nxt.bit_index == LastBit) begin
            nxt.bit_index   = '0;
            nxt.phase       = PhIdle;
            nxt.drive_lines = LinesNone;
            status          = StDone;
          end else begin
            nxt.bit_index   = nxt.bit_index + 3'd1;
            nxt.shift_byte  = {1'b0, nxt.shift_byte[ByteW-1:1]};
            nxt.drive_lines = {nxt.shift_byte[0], ~nxt.shift_byte[0]};
            nxt.phase       = PhSendLow;
          end
        end else begin
          tick = 1'b1;
        end
      end
      PhRecvPull: begin
        if (high == LinesBoth) begin
          tick = 1'b1;
        end else if (high == LinesNone) begin
          nxt.phase       = PhIdle;
          nxt.drive_lines = LinesNone;
          nxt.wait_count  = '0;
          status          = StLinkErr;
        end else begin
          // partner pulled line 1 -> bit is one, shifted in from the top;
          // we pull the line that is still high
          nxt.drive_lines = high;
          nxt.shift_byte  = {high[0], nxt.shift_byte[ByteW-1:1]};
          nxt.wait_count  = '0;
          nxt.phase       = PhRecvRel;
        end
      end
      PhRecvRel: begin
        if (high != LinesNone) begin
          nxt.drive_lines = LinesNone;
          nxt.wait_count  = '0;
          if (nxt.bit_index == LastBit) begin
            nxt.bit_index = '0;
            nxt.phase     = PhIdle;
            status        = StDone;
          end else begin
            nxt.bit_index = nxt.bit_index + 3'd1;
            nxt.phase     = PhRecvPull;
          end
        end else begin
          tick = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (tick) begin
      if (timeout) begin
        nxt.phase       = PhIdle;
        nxt.drive_lines = LinesNone;
        nxt.wait_count  = '0;
        status          = StTimeout;
      end else begin
        nxt.wait_count = wc_inc;
      end
    end

    if (ignored && status == StNone) begin
      status = StIgnored;
    end

    state_o           = nxt;
    result_o.our_pull = nxt.drive_lines;
    result_o.status   = status;
    result_o.rx_byte  = (status == StDone && nxt.is_receive) ? nxt.shift_byte : '0;
    result_o.busy_res = (nxt.phase != PhIdle);
  end

endmodule

>>> rtl/two_wire_handshake_byte_link_core.sv
// ----------------------------------------------------------------------------
// two_wire_handshake_byte_link_core
// One side of a two-wire open-drain byte link, stepped one tick per item.
//
//  channel  dir  signals                          item
//  s_axis   in   s_tvalid/s_tready/s_tdata[15:0]  one sampled tick + command
//  m_axis   out  m_tvalid/m_tready/m_tdata[15:0]  lines, status, rx byte, busy
//  apb      in   psel/penable/pwrite/paddr/...    wait_limit at address 0
//
// An item is latched in the input register, evaluated by the step logic and
// lands in the output register when that slot is free or being drained, one
// item per cycle sustained while the output is not stalled. The state updates
// when the item moves to the output register, so a stalled output holds the
// item and the state alike. Reset clears the link state, sets wait_limit to
// 1000 and empties both registers.
// ----------------------------------------------------------------------------
module two_wire_handshake_byte_link_core
  import twbl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] operation, [9:2] tx_byte, [11:10] partner_pull, [15:12] zero
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] our_pull, [4:2] status, [12:5] rx_byte, [13] busy_res, [15:14] zero
  output logic [15:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [WaitW-1:0] wait_limit_q;
  link_state_t      state_q, state_d;
  link_in_t         item_q;
  logic             in_valid_q;
  link_out_t        res_q, res_d;
  logic             out_valid_q;
  logic             advance;
  logic             cfg_hit;

  assign cfg_hit = (paddr == CfgAddrWaitLimit[0:0]);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? {16'd0, wait_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_limit_q <= WaitLimitReset;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      wait_limit_q <= pwdata[WaitW-1:0];
    end
  end

  // output slot is free or being drained this cycle
  assign advance  = !out_valid_q || m_tready;
  assign s_tready = !in_valid_q || advance;

  twbl_step u_step (
    .state_i      (state_q),
    .item_i       (item_q),
    .wait_limit_i (wait_limit_q),
    .state_o      (state_d),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_tready) begin
        in_valid_q <= s_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready && s_tvalid) begin
      item_q.operation    <= s_tdata[1:0];
      item_q.tx_byte      <= s_tdata[9:2];
      item_q.partner_pull <= s_tdata[11:10];
    end
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {2'b00, res_q.busy_res, res_q.rx_byte, res_q.status, res_q.our_pull};

endmodule
